>>> hw/rtl/key_sorter_defines.svh
// Assertion macros shared by the checker of the key sorter.
`ifndef KEY_SORTER_DEFINES_SVH
`define KEY_SORTER_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define KS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define KS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/ks_pkg.sv
// Types and constants shared by the key sorter modules.
package ks_pkg;

   localparam int DATA_WIDTH = 32;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] key_value;
      logic                  batch_end;
   } req_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] sorted_value;
      logic                  last_out;
      logic                  overflowed;
   } rsp_type;

   typedef enum logic {
      ST_COLLECT,
      ST_DRAIN
   } state_type;

   // Commands from the controller to every cell of the chain.
   typedef struct packed {
      logic insert;
      logic shift;
   } ctrl_type;

   // Chain status seen by the controller.
   typedef struct packed {
      logic head_valid;
      logic head_last;
      logic full;
   } status_type;

endpackage

>>> hw/rtl/key_sorter.sv
// Top level of the key sorter: insertion cell chain plus controller.
//
// Usage:
//   Keys arrive on the req_ channel, one transfer per cycle, each with a
//   batch_end flag on the last key of a batch. Every key drops straight into
//   its sorted place in a row of DEPTH cells, so collection runs at one key
//   per cycle. On the batch_end transfer the block stops taking keys
//   (req_stall high) and drains the row through the rsp_ channel, smallest
//   key first, one result per cycle while rsp_stall is low.
//   The first result shows in the cycle after the batch_end transfer.
//   The row drains by shifting one place per result transfer.
//   last_out marks the final result; overflowed on it reports that keys
//   arrived while all DEPTH cells were full and were dropped.
//   csr_write_en/csr_write_data set signed_order (bit 0): 0 unsigned,
//   1 two's complement compare; write it only while the block is idle.
//   Reset empties the row, clears the overflow flag and signed_order, and
//   leaves the block ready for keys on the next cycle.
//   When the receiver stalls, the head cell holds the result unchanged.
module key_sorter import ks_pkg::*; #(
   parameter int DEPTH     = 64,
   parameter int KEY_WIDTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data,
   input  logic    csr_write_en,
   input  logic    csr_write_data
);

   logic                 signed_ff, signed_in;
   logic [KEY_WIDTH-1:0] new_key;
   logic [KEY_WIDTH-1:0] cell_key  [DEPTH];
   logic                 cell_valid[DEPTH];
   logic                 cell_take [DEPTH];
   ctrl_type             ctl;
   status_type           stat;
   logic                 overflowed;

   // Hold the order bit; only bit 0 of the written value exists on the port.
   assign signed_in = csr_write_en ? csr_write_data : signed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         signed_ff <= 1'b0;
      end else begin
         signed_ff <= signed_in;
      end
   end

   // Fit the 32-bit input key to the cell width.
   if (KEY_WIDTH > DATA_WIDTH) begin : g_key_wide
      assign new_key = {{(KEY_WIDTH-DATA_WIDTH){1'b0}}, req_data.key_value};
   end else begin : g_key_narrow
      assign new_key = req_data.key_value[KEY_WIDTH-1:0];
   end

   // Cell row: cell 0 holds the smallest key and feeds the output.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [KEY_WIDTH-1:0] prev_key, next_key;
      logic                 prev_valid, prev_take, next_valid;

      if (i == 0) begin : g_first
         assign prev_key   = new_key;
         assign prev_valid = 1'b0;
         assign prev_take  = 1'b0;
      end else begin : g_mid
         assign prev_key   = cell_key[i-1];
         assign prev_valid = cell_valid[i-1];
         assign prev_take  = cell_take[i-1];
      end

      if (i == DEPTH-1) begin : g_last
         assign next_key   = cell_key[i];
         assign next_valid = 1'b0;
      end else begin : g_inner
         assign next_key   = cell_key[i+1];
         assign next_valid = cell_valid[i+1];
      end

      ks_cell #(
         .KEY_WIDTH(KEY_WIDTH)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .signed_order(signed_ff),
         .new_key     (new_key),
         .prev_key    (prev_key),
         .prev_valid  (prev_valid),
         .prev_take   (prev_take),
         .next_key    (next_key),
         .next_valid  (next_valid),
         .key         (cell_key[i]),
         .valid       (cell_valid[i]),
         .take        (cell_take[i])
      );
   end

   // The head is the last result when the cell behind it is empty.
   assign stat.head_valid = cell_valid[0];
   assign stat.head_last  = !cell_valid[1];
   assign stat.full       = cell_valid[DEPTH-1];

   ks_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .batch_end (req_data.batch_end),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .overflowed(overflowed),
      .ctl       (ctl)
   );

   // Present the head cell; keys wider than the port give their low bits.
   if (KEY_WIDTH < DATA_WIDTH) begin : g_out_narrow
      assign rsp_data.sorted_value = {{(DATA_WIDTH-KEY_WIDTH){1'b0}}, cell_key[0]};
   end else begin : g_out_wide
      assign rsp_data.sorted_value = cell_key[0][DATA_WIDTH-1:0];
   end
   assign rsp_data.last_out   = stat.head_last;
   assign rsp_data.overflowed = overflowed;

endmodule

>>> hw/rtl/ks_cell.sv
// One sorting cell: holds a key and its valid bit, trades keys with its neighbors.
module ks_cell import ks_pkg::*; #(
   parameter int KEY_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_type             ctl,
   input  logic                 signed_order,
   input  logic [KEY_WIDTH-1:0] new_key,
   input  logic [KEY_WIDTH-1:0] prev_key,
   input  logic                 prev_valid,
   input  logic                 prev_take,
   input  logic [KEY_WIDTH-1:0] next_key,
   input  logic                 next_valid,
   output logic [KEY_WIDTH-1:0] key,
   output logic                 valid,
   output logic                 take
);

   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic                 valid_ff, valid_in;
   logic [KEY_WIDTH-1:0] own_ord, new_ord;

   // Flip the sign bit under signed order so an unsigned compare applies.
   assign own_ord = {key_ff[KEY_WIDTH-1] ^ signed_order, key_ff[KEY_WIDTH-2:0]};
   assign new_ord = {new_key[KEY_WIDTH-1] ^ signed_order, new_key[KEY_WIDTH-2:0]};

   // The new key lands here or further left when this slot is empty or larger.
   assign take = !valid_ff || (own_ord > new_ord);

   always_comb begin
      key_in   = key_ff;
      valid_in = valid_ff;
      if (ctl.insert && take) begin
         if (prev_take) begin
            key_in   = prev_key;
            valid_in = prev_valid;
         end else begin
            key_in   = new_key;
            valid_in = 1'b1;
         end
      end else if (ctl.shift) begin
         key_in   = next_key;
         valid_in = next_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key   = key_ff;
   assign valid = valid_ff;

endmodule

>>> hw/rtl/ks_ctrl.sv
// Collect/drain controller and overflow tracking of the key sorter.
module ks_ctrl import ks_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       batch_end,
   input  logic       rsp_stall,
   input  status_type stat,
   output logic       req_stall,
   output logic       rsp_valid,
   output logic       overflowed,
   output ctrl_type   ctl
);

   state_type state_ff, state_in;
   logic      drop_ff, drop_in;
   logic      req_xfer, rsp_xfer;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid && !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_COLLECT: begin
            if (req_valid && batch_end) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (rsp_xfer && stat.head_last) state_in = ST_COLLECT;
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   always_comb begin
      req_stall  = 1'b1;
      rsp_valid  = 1'b0;
      ctl.insert = 1'b0;
      case (state_ff)
         ST_COLLECT: begin
            req_stall  = 1'b0;
            ctl.insert = req_valid && !stat.full;
         end
         ST_DRAIN: begin
            rsp_valid = stat.head_valid;
         end
         default: req_stall = 1'b1;
      endcase
      ctl.shift  = rsp_xfer;
      overflowed = drop_ff && stat.head_last;
   end

   always_comb begin
      drop_in = drop_ff;
      if (req_xfer && stat.full) drop_in = 1'b1;
      else if (rsp_xfer && stat.head_last) drop_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
         drop_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         drop_ff  <= drop_in;
      end
   end

endmodule

>>> hw/rtl/ks_checker.sv
// Port-level checker of the key sorter and its bind to the top level.
`include "key_sorter_defines.svh"

module ks_checker import ks_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   `KS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")
   `KS_ASSERT_NOW(a_no_take_in_drain, rsp_valid, req_stall, "key taken while results pending")
   `KS_ASSERT_NOW(a_ovf_on_last, rsp_valid && rsp_data.overflowed, rsp_data.last_out, "overflow flag before final result")
   `KS_ASSERT_NEXT(a_drain_starts, req_valid && !req_stall && req_data.batch_end, rsp_valid, "no result after batch end")

endmodule

bind key_sorter ks_checker u_ks_checker (.*);
